// File: rtl/core/scgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgd_pkg
// Shared types, constants and the month table for the seconds to date core.
// ----------------------------------------------------------------------------
package scgd_pkg;

    // epoch shift from 2022-03-21 back to 2022-01-01
    localparam logic [32:0] EPOCH_OFFSET   = 33'd6825600;
    localparam logic [17:0] SECS_PER_DAY   = 18'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

    // reciprocals for the constant divides, each exact over its input range
    // day: (sum >> 7) / 675, scale 2^35, sum >> 7 below 2^25
    localparam logic [25:0] DAY_RECIP      = 26'd50903317;
    localparam logic [9:0]  DAY_ODD        = 10'd675;
    // hour: (sec of day >> 4) / 225, scale 2^21, input below 2^13
    localparam logic [13:0] HOUR_RECIP     = 14'd9321;
    // minute: (sec of hour >> 2) / 15, scale 2^14, input below 2^10
    localparam logic [10:0] MIN_RECIP      = 11'd1093;

    localparam logic [11:0] BASE_YEAR      = 12'd2022;
    localparam logic [6:0]  BASE_MOD100    = 7'd22;
    localparam logic [8:0]  BASE_MOD400    = 9'd22;
    localparam logic [6:0]  LAST_MOD100    = 7'd99;
    localparam logic [8:0]  LAST_MOD400    = 9'd399;
    localparam logic [8:0]  DAYS_YEAR      = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;

    localparam logic [3:0]  FIRST_MONTH    = 4'd1;
    localparam logic [3:0]  LAST_MONTH     = 4'd12;

    // first phase index of each divide step (quotient, then remainder)
    localparam logic        DIV_LAST       = 1'b1;
    localparam logic        HOUR_LAST      = 1'b1;
    localparam logic        MIN_LAST       = 1'b1;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       prep;
        logic       hour_step;
        logic       min_step;
        logic       year_step;
        logic       month_step;
        logic       out_load;
        logic       idx;
    } scgd_cmd_t;

    typedef struct packed {
        logic year_more;
        logic month_more;
    } scgd_status_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/scgd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgd_ctrl
// Sequencer for the divide, time split, year walk and month walk phases.
// ----------------------------------------------------------------------------
module scgd_ctrl import scgd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  scgd_status_t status,
    output scgd_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIV    = 8'b0000_0010,
        ST_PREP   = 8'b0000_0100,
        ST_HOUR   = 8'b0000_1000,
        ST_MIN    = 8'b0001_0000,
        ST_YEAR   = 8'b0010_0000,
        ST_MONTH  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic       step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.idx    = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = DIV_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == 1'b0)
                    state_next = ST_PREP;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = HOUR_LAST;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                cmd.hour_step = 1'b1;
                if (step_reg == 1'b0)
                begin
                    step_next  = MIN_LAST;
                    state_next = ST_MIN;
                end
                else
                    step_next = step_reg - 1'b1;
            end
            ST_MIN:
            begin
                cmd.min_step = 1'b1;
                if (step_reg == 1'b0)
                    state_next = ST_YEAR;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_YEAR:
            begin
                if (status.year_more)
                    cmd.year_step = 1'b1;
                else
                    state_next = ST_MONTH;
            end
            ST_MONTH:
            begin
                if (status.month_more)
                    cmd.month_step = 1'b1;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // output slot free or draining this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/scgd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgd_datapath
// Reciprocal day divide, time split, year and month walk, output register.
// ----------------------------------------------------------------------------
module scgd_datapath import scgd_pkg::*; (
    input  logic         clk,
    input  scgd_cmd_t    cmd,
    output scgd_status_t status,
    input  logic [31:0]  counter,
    output logic [11:0]  year,
    output logic [3:0]   month,
    output logic [4:0]   day,
    output logic [4:0]   hour,
    output logic [5:0]   minute,
    output logic [5:0]   second,
    output logic [2:0]   weekday,
    output logic         overflow
);

    logic [31:0] dvd_reg;      // wrapped offset sum
    logic [15:0] q_reg;        // whole days in the sum
    logic [16:0] rem_reg;      // second of day, then what is left of it
    logic [2:0]  r7_reg;       // day quotient mod 7
    logic        ovf_reg;
    logic [15:0] days_reg;
    logic [11:0] year_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  month_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;

    logic [11:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic [4:0]  hour_out_reg;
    logic [5:0]  minute_out_reg;
    logic [5:0]  second_out_reg;
    logic [2:0]  wday_out_reg;
    logic        ovf_out_reg;

    logic [32:0] sum;
    logic [50:0] day_prod;
    logic [24:0] day_back;
    logic [24:0] day_left;
    logic [5:0]  fold6;
    logic [3:0]  fold4;
    logic [2:0]  fold3;
    logic [2:0]  r7_next;
    logic [25:0] hour_prod;
    logic [16:0] hour_back;
    logic [19:0] min_prod;
    logic [16:0] min_back;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    assign sum   = {1'b0, counter} + EPOCH_OFFSET;

    // days = (sum >> 7) / 675 by reciprocal, remainder rebuilt next cycle
    assign day_prod = {26'd0, dvd_reg[31:7]} * {25'd0, DAY_RECIP};
    assign day_back = {9'd0, q_reg} * {15'd0, DAY_ODD};
    assign day_left = dvd_reg[31:7] - day_back;

    // mod 7 by folding octal digits, eight folds to one
    assign fold6   = {3'd0, q_reg[2:0]} + {3'd0, q_reg[5:3]} + {3'd0, q_reg[8:6]}
                   + {3'd0, q_reg[11:9]} + {3'd0, q_reg[14:12]} + {5'd0, q_reg[15]};
    assign fold4   = {1'b0, fold6[2:0]} + {1'b0, fold6[5:3]};
    assign fold3   = fold4[2:0] + {2'd0, fold4[3]};
    assign r7_next = (fold3 == 3'd7) ? 3'd0 : fold3;

    assign hour_prod = {13'd0, rem_reg[16:4]} * {12'd0, HOUR_RECIP};
    assign hour_back = {12'd0, hour_reg} * {5'd0, SECS_PER_HOUR};
    assign min_prod  = {10'd0, rem_reg[11:2]} * {9'd0, MIN_RECIP};
    assign min_back  = {11'd0, minute_reg} * {11'd0, SECS_PER_MIN};

    assign leap = (year_reg[1:0] == 2'd0) &&
                  ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
    assign mlen = month_days(month_reg, leap);

    assign status.year_more  = (days_reg > 16'(ylen));
    assign status.month_more = (month_reg != LAST_MONTH) && (days_reg > 16'(mlen));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg <= sum[31:0];
            ovf_reg <= sum[32];
        end
        if (cmd.div_step)
        begin
            if (cmd.idx)
                q_reg <= day_prod[50:35];
            else
                rem_reg <= {day_left[9:0], dvd_reg[6:0]};
        end
        if (cmd.prep)
        begin
            days_reg   <= q_reg + 16'd1;
            r7_reg     <= r7_next;
            year_reg   <= BASE_YEAR;
            c100_reg   <= BASE_MOD100;
            c400_reg   <= BASE_MOD400;
            month_reg  <= FIRST_MONTH;
        end
        if (cmd.hour_step)
        begin
            if (cmd.idx)
                hour_reg <= hour_prod[25:21];
            else
                rem_reg <= rem_reg - hour_back;
        end
        if (cmd.min_step)
        begin
            if (cmd.idx)
                minute_reg <= min_prod[19:14];
            else
                rem_reg <= rem_reg - min_back;
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - 16'(ylen);
            year_reg <= year_reg + 12'd1;
            c100_reg <= (c100_reg == LAST_MOD100) ? 7'd0 : c100_reg + 7'd1;
            c400_reg <= (c400_reg == LAST_MOD400) ? 9'd0 : c400_reg + 9'd1;
        end
        if (cmd.month_step)
        begin
            days_reg  <= days_reg - 16'(mlen);
            month_reg <= month_reg + 4'd1;
        end
        if (cmd.out_load)
        begin
            year_out_reg   <= year_reg;
            month_out_reg  <= month_reg;
            day_out_reg    <= days_reg[4:0];
            hour_out_reg   <= hour_reg;
            minute_out_reg <= minute_reg;
            second_out_reg <= rem_reg[5:0];
            wday_out_reg   <= r7_reg;
            ovf_out_reg    <= ovf_reg;
        end
    end

    assign year     = year_out_reg;
    assign month    = month_out_reg;
    assign day      = day_out_reg;
    assign hour     = hour_out_reg;
    assign minute   = minute_out_reg;
    assign second   = second_out_reg;
    assign weekday  = wday_out_reg;
    assign overflow = ovf_out_reg;

endmodule

// File: rtl/core/seconds_counter_to_gregorian_date_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seconds_counter_to_gregorian_date_core
// Converts a 32-bit RTC seconds count (zero at 2022-03-21) into calendar date,
// time of day and weekday under the full Gregorian leap rule.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | counter
//  out     | out_valid/out_stall | year month day hour minute second
//          |                     | weekday overflow
//
// an item steps through load, the day divide, prep, the hour and minute splits,
// one year step per whole year and one month step per whole month past the
// start of 2022, then the hand-off to the output register
// the day divide is a reciprocal multiply, quotient then remainder
// rst_n clears the sequencer and the output valid flag only
// the result sits in its own output register, so the next item is taken
// while an earlier result is still stalled; a finished item waits for that
// register to free up before it is written
//
module seconds_counter_to_gregorian_date_core import scgd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] counter,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday,
    output logic        overflow
);

    scgd_cmd_t    cmd;
    scgd_status_t status;

    // sequencer: accept, divide, split time, walk years, walk months, hand off
    scgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and the output register
    scgd_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .status   (status),
        .counter  (counter),
        .year     (year),
        .month    (month),
        .day      (day),
        .hour     (hour),
        .minute   (minute),
        .second   (second),
        .weekday  (weekday),
        .overflow (overflow)
    );

endmodule

// File: rtl/core/scgd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgd_checker
// Port-level checks on the result channel of the seconds to date core.
// ----------------------------------------------------------------------------
module scgd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  weekday,
    input logic        overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(year) && $stable(month) && $stable(day)
            && $stable(hour) && $stable(minute) && $stable(second)
            && $stable(weekday) && $stable(overflow))
        else $error("stalled result item changed");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 12'd2022 && year <= 12'd2158 && month >= 4'd1
            && month <= 4'd12 && day >= 5'd1 && day <= 5'd31)
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
            && weekday <= 3'd6)
        else $error("time field out of range");

    a_wrap_early: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> year == 12'd2022 && month <= 4'd3)
        else $error("wrapped sum not early in 2022");

endmodule

bind seconds_counter_to_gregorian_date_core scgd_checker u_scgd_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seconds counter to Gregorian date core. A local
// calendar model predicts year, month, day, time of day, weekday and offset
// overflow for every accepted counter item. Each result is checked field by
// field against the oldest prediction. Directed calendar corners run first,
// then random traffic under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import scgd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 250;     // one full worst-case item and some
    localparam int REPORT_MAX   = 10;
    localparam int ITEMS_PHASE  = 200;

    // first counter value whose offset sum no longer fits in 32 bits
    localparam logic [31:0] WRAP_POINT = 32'hFFFF_FFFF - 32'd6825600 + 32'd1;

    localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic        overflow;
    } date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] counter = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        overflow;

    date_t pending_dates [$];
    int    mismatch_cnt = 0;
    int    cycle_cnt = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;

    seconds_counter_to_gregorian_date_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .counter  (counter),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .year     (year),
        .month    (month),
        .day      (day),
        .hour     (hour),
        .minute   (minute),
        .second   (second),
        .weekday  (weekday),
        .overflow (overflow)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------------

    function automatic bit is_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(input int y, input int m);
        if (m == 2 && is_leap(y))
            return 29;
        return MONTH_LEN[m - 1];
    endfunction

    // expected result for one counter value
    function automatic date_t calendar_of(input logic [31:0] c);
        logic [32:0] total;
        logic [31:0] wrapped;
        int unsigned secs;
        int unsigned days;
        int          yr;
        int          mo;
        date_t       r;
        total   = {1'b0, c} + EPOCH_OFFSET;
        wrapped = total[31:0];
        secs    = wrapped % SECS_PER_DAY;
        days    = wrapped / SECS_PER_DAY + 1;
        yr      = BASE_YEAR;
        mo      = 1;
        r.weekday  = 3'((days + 6) % 7);
        r.overflow = total[32];
        // peel whole years, then whole months
        while (days > (is_leap(yr) ? 366 : 365))
        begin
            days -= is_leap(yr) ? 366 : 365;
            yr++;
        end
        while (mo < 12 && days > days_in_month(yr, mo))
        begin
            days -= days_in_month(yr, mo);
            mo++;
        end
        r.year   = 12'(yr);
        r.month  = 4'(mo);
        r.day    = 5'(days);
        r.hour   = 5'(secs / 3600);
        r.minute = 6'((secs / 60) % 60);
        r.second = 6'(secs % 60);
        return r;
    endfunction

    // counter value that lands on a given date and time, wrapping below the epoch
    function automatic logic [31:0] counter_at(input int y, input int m, input int d,
                                               input int hh, input int mm, input int ss);
        longint total;
        total = 0;
        for (int i = BASE_YEAR; i < y; i++)
            total += (is_leap(i) ? 366 : 365) * 86400;
        for (int i = 1; i < m; i++)
            total += days_in_month(y, i) * 86400;
        total += (d - 1) * 86400 + hh * 3600 + mm * 60 + ss;
        return 32'(total - longint'(EPOCH_OFFSET));
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // random idle gap, then hold the item until it is taken
    task automatic send_item(input logic [31:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        counter  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_dates.push_back(calendar_of(c));
    endtask

    task automatic send_date(input int y, input int m, input int d,
                             input int hh, input int mm, input int ss);
        send_item(counter_at(y, m, d, hh, mm, ss));
    endtask

    // stop sending until every outstanding result is back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------

    task automatic note_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        date_t want;
        date_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{year, month, day, hour, minute, second, weekday, overflow};
            if (pending_dates.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected result %0d-%0d-%0d", year, month, day);
            end
            else
            begin
                want = pending_dates.pop_front();
                note_field("year", 32'(want.year), 32'(got.year));
                note_field("month", 32'(want.month), 32'(got.month));
                note_field("day", 32'(want.day), 32'(got.day));
                note_field("hour", 32'(want.hour), 32'(got.hour));
                note_field("minute", 32'(want.minute), 32'(got.minute));
                note_field("second", 32'(want.second), 32'(got.second));
                note_field("weekday", 32'(want.weekday), 32'(got.weekday));
                note_field("overflow", 32'(want.overflow), 32'(got.overflow));
            end
        end
    end

    // watchdog: a stuck handshake ends the run here
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // all-zero, all-one, single top bit and all-but-top-bit counters
    task automatic test_input_extremes();
        send_item(32'h0000_0000);
        send_item(32'hFFFF_FFFF);
        send_item(32'h8000_0000);
        send_item(32'h7FFF_FFFF);
    endtask

    // offset sum right below and right past 2^32, and either side of the next day start
    task automatic test_offset_overflow();
        send_item(WRAP_POINT - 32'd1);
        send_item(WRAP_POINT);
        send_item(WRAP_POINT + 32'd86399);
        send_item(WRAP_POINT + 32'd86400);
    endtask

    // year, month and leap-day boundaries, the non-leap century among them
    task automatic test_calendar_edges();
        send_date(2022, 12, 31, 23, 59, 59);
        send_date(2023, 1, 1, 0, 0, 0);
        send_date(2024, 2, 28, 23, 59, 59);
        send_date(2024, 2, 29, 12, 34, 56);
        send_date(2024, 3, 1, 0, 0, 0);
        send_date(2030, 4, 30, 23, 59, 59);
        send_date(2100, 2, 28, 23, 59, 59);
        send_date(2100, 3, 1, 0, 0, 0);
        send_date(2157, 12, 31, 23, 59, 59);
        send_date(2158, 1, 1, 0, 0, 0);
    endtask

    // lone items on an empty pipe
    task automatic test_isolated_items();
        wait_all_results();
        send_date(2040, 7, 15, 6, 30, 0);
        wait_all_results();
        send_date(2096, 2, 29, 18, 0, 1);
    endtask

    // mix of raw counters, valid dates, month edges and the wrap region
    task automatic test_random_traffic(input int n, input int idle, input int stall);
        int          kind;
        int          y;
        int          m;
        logic [31:0] c;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            y    = $urandom_range(2157, BASE_YEAR);
            m    = $urandom_range(12, 1);
            if (kind < 30)
                c = $urandom;
            else if (kind < 70)
                c = counter_at(y, m, $urandom_range(days_in_month(y, m), 1),
                               $urandom_range(23), $urandom_range(59), $urandom_range(59));
            else if (kind < 90)
                c = counter_at(y, m, 1, 0, 0, 0) + $urandom_range(3) - 32'd2;
            else
                c = WRAP_POINT + $urandom_range(13651199) - 32'd6825600;
            send_item(c);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_input_extremes();
        test_offset_overflow();
        test_calendar_edges();
        test_isolated_items();

        test_random_traffic(ITEMS_PHASE, 0, 0);
        test_random_traffic(ITEMS_PHASE, 65, 0);
        test_random_traffic(ITEMS_PHASE, 0, 65);
        test_random_traffic(ITEMS_PHASE, 25, 25);

        wait_all_results();
        // extra time to catch a stray result
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/scgd_pkg.sv
rtl/core/scgd_ctrl.sv
rtl/core/scgd_datapath.sv
rtl/core/seconds_counter_to_gregorian_date_core.sv
rtl/core/scgd_checker.sv
sim/tb.sv
